>>> sv/mpwa_pkg.sv
// Shared types and constants of the max pooling window argmax block.
package mpwa_pkg;

  // Storage geometry.
  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned MAX_COLS    = 64;
  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS * CHANNELS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned PIX_W       = $clog2(MAX_ROWS * MAX_COLS);
  localparam int unsigned CH_W        = $clog2(CHANNELS);

  // Field and register widths.
  localparam int unsigned POS_W   = 6;
  localparam int unsigned PPOS_W  = 7;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned PAD_W   = 6;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W  = 2 * PPOS_W;
  localparam int unsigned CLIP_W  = PROD_W + 2;
  localparam int unsigned IDX_W   = 16;

  localparam logic [DIM_W-1:0] ROWS_LIMIT = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_LIMIT = DIM_W'(MAX_COLS);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_STEP_ROWS     = 3'd4,
    REG_STEP_COLS     = 3'd5,
    REG_PAD_TOP_ROWS  = 3'd6,
    REG_PAD_LEFT_COLS = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_CLIP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    opcode_e                        opcode;
    logic [POS_W-1:0]               row;
    logic [POS_W-1:0]               col;
    logic [CH_W-1:0]                channel;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic [PPOS_W-1:0]              pooled_row;
    logic [PPOS_W-1:0]              pooled_col;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]  max_value;
    logic [IDX_W-1:0]               max_index;
    logic                           window_empty;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_write;
    logic do_mul;
    logic do_clip;
    logic scan_issue;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clip_empty;
    logic window_empty;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/max_pool_window_argmax_core.sv
// Max pooling with argmax over one image held in a 64 x 64 x 16 sample
// store, channels-last. A load item writes one sample in the load state
// before the next item can be taken; loads outside the current image size
// are dropped. A query item reads its clipped window one sample per cycle
// through the store's single read port; it passes the multiply, clip, scan,
// drain and done states, and a window that clipping leaves empty skips the
// scan and drain. The result sits in an output register, so the next item is
// taken while it waits for its transfer. The user must write configuration
// only while the block is idle; the block itself does not enforce it. Changing
// the image width changes the store layout, so samples must then be reloaded.
module max_pool_window_argmax_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpwa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mpwa_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mpwa_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mpwa_pkg::out_item_t               out_data_o
);

  mpwa_pkg::ctrl_cmd_t cmd;
  mpwa_pkg::dp_sts_t   sts;

  // Sequencer.
  mpwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_opcode_i(in_data_i.opcode),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath with the sample store.
  mpwa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> sv/mpwa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mpwa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mpwa_ctrl.sv
// Sequencer for loads and window scans.
module mpwa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mpwa_pkg::opcode_e   in_opcode_i,
  output logic                in_stall_o,
  input  mpwa_pkg::dp_sts_t   sts_i,
  output mpwa_pkg::ctrl_cmd_t cmd_o
);

  mpwa_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpwa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpwa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_opcode_i == mpwa_pkg::OP_LOAD) ? mpwa_pkg::ST_LOAD
                                                       : mpwa_pkg::ST_MUL;
        end
      end
      mpwa_pkg::ST_LOAD:  state_d = mpwa_pkg::ST_IDLE;
      mpwa_pkg::ST_MUL:   state_d = mpwa_pkg::ST_CLIP;
      mpwa_pkg::ST_CLIP: begin
        state_d = sts_i.clip_empty ? mpwa_pkg::ST_DONE : mpwa_pkg::ST_SCAN;
      end
      mpwa_pkg::ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = mpwa_pkg::ST_DRAIN;
        end
      end
      mpwa_pkg::ST_DRAIN: state_d = mpwa_pkg::ST_DONE;
      mpwa_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = mpwa_pkg::ST_IDLE;
        end
      end
      default: state_d = mpwa_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mpwa_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      mpwa_pkg::ST_LOAD:  cmd_o.load_write = 1'b1;
      mpwa_pkg::ST_MUL:   cmd_o.do_mul     = 1'b1;
      mpwa_pkg::ST_CLIP:  cmd_o.do_clip    = 1'b1;
      mpwa_pkg::ST_SCAN:  cmd_o.scan_issue = 1'b1;
      mpwa_pkg::ST_DRAIN: cmd_o            = '0;
      mpwa_pkg::ST_DONE:  cmd_o.out_load   = sts_i.out_free;
      default:            cmd_o            = '0;
    endcase
  end

`ifndef SYNTHESIS
  // A scan never starts on a window that clipping left empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpwa_pkg::ST_SCAN) |-> !sts_i.window_empty)
    else $error("scan running on an empty window");
`endif

endmodule

>>> sv/mpwa_dp.sv
// Datapath: configuration registers, sample store, window bounds, scan
// counters, running maximum and the result register.
module mpwa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [mpwa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mpwa_pkg::CFG_W-1:0]     cfg_data_i,
  input  mpwa_pkg::in_item_t  in_data_i,
  input  mpwa_pkg::ctrl_cmd_t cmd_i,
  output mpwa_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpwa_pkg::out_item_t out_data_o
);

  // Configuration registers.
  logic [mpwa_pkg::DIM_W-1:0] img_h_q, img_w_q, win_h_q, win_w_q;
  logic [mpwa_pkg::DIM_W-1:0] step_r_q, step_c_q;
  logic [mpwa_pkg::PAD_W-1:0] pad_t_q, pad_l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q  <= mpwa_pkg::DIM_W'(64);
      img_w_q  <= mpwa_pkg::DIM_W'(64);
      win_h_q  <= mpwa_pkg::DIM_W'(2);
      win_w_q  <= mpwa_pkg::DIM_W'(2);
      step_r_q <= mpwa_pkg::DIM_W'(2);
      step_c_q <= mpwa_pkg::DIM_W'(2);
      pad_t_q  <= '0;
      pad_l_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (mpwa_pkg::cfg_reg_e'(cfg_index_i))
        mpwa_pkg::REG_IMAGE_HEIGHT:  img_h_q  <= cfg_data_i;
        mpwa_pkg::REG_IMAGE_WIDTH:   img_w_q  <= cfg_data_i;
        mpwa_pkg::REG_WINDOW_HEIGHT: win_h_q  <= cfg_data_i;
        mpwa_pkg::REG_WINDOW_WIDTH:  win_w_q  <= cfg_data_i;
        mpwa_pkg::REG_STEP_ROWS:     step_r_q <= cfg_data_i;
        mpwa_pkg::REG_STEP_COLS:     step_c_q <= cfg_data_i;
        mpwa_pkg::REG_PAD_TOP_ROWS:  pad_t_q  <= cfg_data_i[mpwa_pkg::PAD_W-1:0];
        mpwa_pkg::REG_PAD_LEFT_COLS: pad_l_q  <= cfg_data_i[mpwa_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Image size saturated to the store geometry.
  logic [mpwa_pkg::DIM_W-1:0] img_h, img_w;
  assign img_h = (img_h_q > mpwa_pkg::ROWS_LIMIT) ? mpwa_pkg::ROWS_LIMIT : img_h_q;
  assign img_w = (img_w_q > mpwa_pkg::COLS_LIMIT) ? mpwa_pkg::COLS_LIMIT : img_w_q;

  // Item register, filled on each input transfer.
  mpwa_pkg::in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // Load path: address of the sample and bounds check.
  logic [mpwa_pkg::PIX_W:0]    load_prod;
  logic [mpwa_pkg::PIX_W-1:0]  load_pix;
  logic                        load_ok;
  logic [mpwa_pkg::ADDR_W-1:0] waddr;

  assign load_prod = (mpwa_pkg::PIX_W+1)'(item_q.row) * (mpwa_pkg::PIX_W+1)'(img_w);
  assign load_pix  = mpwa_pkg::PIX_W'(load_prod + (mpwa_pkg::PIX_W+1)'(item_q.col));
  assign load_ok   = (mpwa_pkg::DIM_W'(item_q.row) < img_h)
                  && (mpwa_pkg::DIM_W'(item_q.col) < img_w);
  assign waddr     = {load_pix, item_q.channel};

  // Window start products, one multiply per axis.
  logic [mpwa_pkg::PROD_W-1:0] prod_r_q, prod_c_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_mul) begin
      prod_r_q <= mpwa_pkg::PROD_W'(item_q.pooled_row) * mpwa_pkg::PROD_W'(step_r_q);
      prod_c_q <= mpwa_pkg::PROD_W'(item_q.pooled_col) * mpwa_pkg::PROD_W'(step_c_q);
    end
  end

  // Window bounds, clipped to the image.
  logic signed [mpwa_pkg::CLIP_W-1:0] hs, he, ws, we;
  logic signed [mpwa_pkg::CLIP_W-1:0] hs_c, he_c, ws_c, we_c, he_m1, we_m1;
  logic                               clip_empty;

  always_comb begin
    hs    = mpwa_pkg::CLIP_W'(prod_r_q) - mpwa_pkg::CLIP_W'(pad_t_q);
    ws    = mpwa_pkg::CLIP_W'(prod_c_q) - mpwa_pkg::CLIP_W'(pad_l_q);
    he    = hs + mpwa_pkg::CLIP_W'(win_h_q);
    we    = ws + mpwa_pkg::CLIP_W'(win_w_q);
    hs_c  = hs[mpwa_pkg::CLIP_W-1] ? '0 : hs;
    ws_c  = ws[mpwa_pkg::CLIP_W-1] ? '0 : ws;
    he_c  = (he > $signed(mpwa_pkg::CLIP_W'(img_h))) ? $signed(mpwa_pkg::CLIP_W'(img_h)) : he;
    we_c  = (we > $signed(mpwa_pkg::CLIP_W'(img_w))) ? $signed(mpwa_pkg::CLIP_W'(img_w)) : we;
    he_m1 = he_c - mpwa_pkg::CLIP_W'(1);
    we_m1 = we_c - mpwa_pkg::CLIP_W'(1);
    clip_empty = !(he_c > hs_c) || !(we_c > ws_c);
  end

  // Scan counters over the clipped window, row-major.
  logic [mpwa_pkg::POS_W-1:0] h_q, w_q, w_first_q, h_last_q, w_last_q;
  logic                       empty_q;
  logic                       scan_last;

  assign scan_last = (h_q == h_last_q) && (w_q == w_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b0;
    end else if (cmd_i.do_clip) begin
      empty_q <= clip_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_clip) begin
      h_q       <= hs_c[mpwa_pkg::POS_W-1:0];
      w_q       <= ws_c[mpwa_pkg::POS_W-1:0];
      w_first_q <= ws_c[mpwa_pkg::POS_W-1:0];
      h_last_q  <= he_m1[mpwa_pkg::POS_W-1:0];
      w_last_q  <= we_m1[mpwa_pkg::POS_W-1:0];
    end else if (cmd_i.scan_issue) begin
      if (w_q == w_last_q) begin
        w_q <= w_first_q;
        h_q <= h_q + mpwa_pkg::POS_W'(1);
      end else begin
        w_q <= w_q + mpwa_pkg::POS_W'(1);
      end
    end
  end

  // Read address of the current window position.
  logic [mpwa_pkg::PIX_W:0]    scan_prod;
  logic [mpwa_pkg::PIX_W-1:0]  scan_pix;
  logic [mpwa_pkg::ADDR_W-1:0] raddr;

  assign scan_prod = (mpwa_pkg::PIX_W+1)'(h_q) * (mpwa_pkg::PIX_W+1)'(img_w);
  assign scan_pix  = mpwa_pkg::PIX_W'(scan_prod + (mpwa_pkg::PIX_W+1)'(w_q));
  assign raddr     = {scan_pix, item_q.channel};

  // Sample store.
  logic [mpwa_pkg::SAMPLE_BITS-1:0] rdata;

  mpwa_ram #(
    .WIDTH(mpwa_pkg::SAMPLE_BITS),
    .DEPTH(mpwa_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_write && load_ok),
    .waddr_i(waddr),
    .wdata_i(item_q.sample),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Compare stage: works in the cycle after the store read, on the registered read data.
  logic                              rd_valid_q;
  logic [mpwa_pkg::ADDR_W-1:0]       rd_addr_q;
  logic                              found_q;
  logic signed [mpwa_pkg::SAMPLE_BITS-1:0] best_q;
  logic [mpwa_pkg::ADDR_W-1:0]       best_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_issue;
      if (cmd_i.do_clip) begin
        found_q <= 1'b0;
      end else if (rd_valid_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_addr_q <= raddr;
    end
    if (rd_valid_q && (!found_q || ($signed(rdata) > best_q))) begin
      best_q     <= $signed(rdata);
      best_idx_q <= rd_addr_q;
    end
  end

  // Result register.
  logic                out_valid_q;
  mpwa_pkg::out_item_t out_q;
  logic                out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.max_value    <= empty_q ? mpwa_pkg::SAMPLE_MIN : best_q;
      out_q.max_index    <= empty_q ? '0 : mpwa_pkg::IDX_W'(best_idx_q);
      out_q.window_empty <= empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.clip_empty   = clip_empty;
  assign sts_o.window_empty = empty_q;
  assign sts_o.scan_last    = scan_last;
  assign sts_o.out_free     = out_free;

`ifndef SYNTHESIS
  // The result register is only loaded when its previous content is gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result register overwritten");

  // Every scan read lies inside the stored image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> ((mpwa_pkg::DIM_W'(h_q) < img_h) && (mpwa_pkg::DIM_W'(w_q) < img_w)))
    else $error("scan position outside the image");

  // A non-empty window has compared at least one sample before its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !empty_q) |-> (found_q && !rd_valid_q))
    else $error("result taken before the scan finished");
`endif

endmodule

>>> bench/tb_max_pool_window_argmax_core.sv
`timescale 1ns / 100ps

module tb_max_pool_window_argmax_core;
  import mpwa_pkg::*;

  localparam longint RUN_LIMIT_NS = 64'd20_000_000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     SETTLE       = 16;
  localparam int     PHASE_PICKS  = 28;

  // Golden pooling model, the queue of pooled results still owed, and the checker.
  class argmax_scoreboard;
    logic [CFG_W-1:0]              cfg_regs [8];
    logic signed [SAMPLE_BITS-1:0] samples [0:STORE_DEPTH-1];
    out_item_t                     expected_maxima [$];
    int unsigned                   mismatches;

    function new();
      cfg_regs[REG_IMAGE_HEIGHT]  = 7'd64;
      cfg_regs[REG_IMAGE_WIDTH]   = 7'd64;
      cfg_regs[REG_WINDOW_HEIGHT] = 7'd2;
      cfg_regs[REG_WINDOW_WIDTH]  = 7'd2;
      cfg_regs[REG_STEP_ROWS]     = 7'd2;
      cfg_regs[REG_STEP_COLS]     = 7'd2;
      cfg_regs[REG_PAD_TOP_ROWS]  = 7'd0;
      cfg_regs[REG_PAD_LEFT_COLS] = 7'd0;
      mismatches = 0;
    endfunction

    // The padding registers are only six bits wide.
    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      if (idx == REG_PAD_TOP_ROWS || idx == REG_PAD_LEFT_COLS)
        cfg_regs[idx] = {1'b0, val[PAD_W-1:0]};
      else
        cfg_regs[idx] = val;
    endfunction

    // Image sizes above the store geometry saturate.
    function int eff_height();
      return (int'(cfg_regs[REG_IMAGE_HEIGHT]) > MAX_ROWS) ? MAX_ROWS
                                                          : int'(cfg_regs[REG_IMAGE_HEIGHT]);
    endfunction

    function int eff_width();
      return (int'(cfg_regs[REG_IMAGE_WIDTH]) > MAX_COLS) ? MAX_COLS
                                                         : int'(cfg_regs[REG_IMAGE_WIDTH]);
    endfunction

    function int flat_addr(int r, int c, logic [CH_W-1:0] ch);
      return (r * eff_width() + c) * CHANNELS + int'(ch);
    endfunction

    // Window bounds after clipping to the image; the upper bounds are exclusive.
    function void clip_window(input logic [PPOS_W-1:0] prow, input logic [PPOS_W-1:0] pcol,
                              output int row_lo, output int row_hi,
                              output int col_lo, output int col_hi);
      row_lo = int'(prow) * int'(cfg_regs[REG_STEP_ROWS]) - int'(cfg_regs[REG_PAD_TOP_ROWS]);
      col_lo = int'(pcol) * int'(cfg_regs[REG_STEP_COLS]) - int'(cfg_regs[REG_PAD_LEFT_COLS]);
      row_hi = row_lo + int'(cfg_regs[REG_WINDOW_HEIGHT]);
      col_hi = col_lo + int'(cfg_regs[REG_WINDOW_WIDTH]);
      if (row_hi > eff_height()) row_hi = eff_height();
      if (col_hi > eff_width()) col_hi = eff_width();
      if (row_lo < 0) row_lo = 0;
      if (col_lo < 0) col_lo = 0;
    endfunction

    // A load updates the store; a query scans its window for the first strict maximum.
    function void note_transfer(in_item_t it);
      int row_lo, row_hi, col_lo, col_hi, addr;
      logic signed [SAMPLE_BITS-1:0] best;
      int best_addr;
      bit found;
      out_item_t res;
      if (it.opcode == OP_LOAD) begin
        if (int'(it.row) < eff_height() && int'(it.col) < eff_width())
          samples[flat_addr(int'(it.row), int'(it.col), it.channel)] = it.sample;
        return;
      end
      clip_window(it.pooled_row, it.pooled_col, row_lo, row_hi, col_lo, col_hi);
      found = 1'b0;
      best = SAMPLE_MIN;
      best_addr = 0;
      for (int r = row_lo; r < row_hi; r++) begin
        for (int c = col_lo; c < col_hi; c++) begin
          addr = flat_addr(r, c, it.channel);
          if (!found || samples[addr] > best) begin
            best = samples[addr];
            best_addr = addr;
            found = 1'b1;
          end
        end
      end
      res.max_value    = found ? best : SAMPLE_MIN;
      res.max_index    = found ? IDX_W'(best_addr) : '0;
      res.window_empty = !found;
      expected_maxima.push_back(res);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 50) $display("mismatch: %s", what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_maxima.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = expected_maxima.pop_front();
      if (got.max_value !== want.max_value)
        report($sformatf("max_value %0d, expected %0d", got.max_value, want.max_value));
      if (got.max_index !== want.max_index)
        report($sformatf("max_index %0d, expected %0d", got.max_index, want.max_index));
      if (got.window_empty !== want.window_empty)
        report($sformatf("window_empty %b, expected %b", got.window_empty, want.window_empty));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_item_t        out_data_o;

  argmax_scoreboard sb = new();

  // Store entries that hold a sample; queries never touch any other entry.
  bit loaded [0:STORE_DEPTH-1];

  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_req;
  int hold_left;

  max_pool_window_argmax_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Every output transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_max_pool_window_argmax_core NOT OK");
    $finish;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_BITS'($urandom_range(0, 6) - 3);
      1: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MIN;
          1: return 16'sh7fff;
          2: return 16'sh8001;
          default: return 16'sh7ffe;
        endcase
      end
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Fields that the opcode does not use still carry random bits.
  function automatic in_item_t random_fields();
    logic [$bits(in_item_t)-1:0] raw;
    raw = $bits(in_item_t)'({$urandom, $urandom});
    return in_item_t'(raw);
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(it);
  endtask

  task automatic push_load(int r, int c, logic [CH_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] v);
    in_item_t it;
    it = random_fields();
    it.opcode  = OP_LOAD;
    it.row     = POS_W'(r);
    it.col     = POS_W'(c);
    it.channel = ch;
    it.sample  = v;
    if (r < sb.eff_height() && c < sb.eff_width()) loaded[sb.flat_addr(r, c, ch)] = 1'b1;
    send_item(it);
  endtask

  // Any entry of the clipped window not yet loaded is loaded before the query.
  task automatic push_query(int pr, int pc, logic [CH_W-1:0] ch);
    int row_lo, row_hi, col_lo, col_hi;
    in_item_t it;
    sb.clip_window(PPOS_W'(pr), PPOS_W'(pc), row_lo, row_hi, col_lo, col_hi);
    for (int r = row_lo; r < row_hi; r++)
      for (int c = col_lo; c < col_hi; c++)
        if (!loaded[sb.flat_addr(r, c, ch)]) push_load(r, c, ch, rand_sample());
    it = random_fields();
    it.opcode     = OP_QUERY;
    it.pooled_row = PPOS_W'(pr);
    it.pooled_col = PPOS_W'(pc);
    it.channel    = ch;
    send_item(it);
  endtask

  // Let the input go quiet and wait until every owed result has arrived.
  task automatic await_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_maxima.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(val);
    @(posedge clk_i);
    sb.write_reg(idx, CFG_W'(val));
  endtask

  task automatic apply_config(int h, int w, int wh, int ww, int sr, int sc, int pt, int pl);
    await_results();
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_STEP_ROWS, sr);
    write_reg(REG_STEP_COLS, sc);
    write_reg(REG_PAD_TOP_ROWS, pt);
    write_reg(REG_PAD_LEFT_COLS, pl);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int window_dim();
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
  endfunction

  function automatic int stride();
    return ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 4);
  endfunction

  // Mostly small images; now and then one dimension at the store maximum.
  task automatic apply_random_config();
    int h, w;
    h = $urandom_range(1, 10);
    w = $urandom_range(1, 10);
    if ($urandom_range(0, 5) == 0) w = MAX_COLS;
    else if ($urandom_range(0, 5) == 0) h = MAX_ROWS;
    apply_config(h, w, window_dim(), window_dim(), stride(), stride(),
                 $urandom_range(0, 3), $urandom_range(0, 3));
  endtask

  // Pooled position whose window lands on or next to the image.
  function automatic int near_pooled(int step, int pad, int size);
    int top;
    if (step == 0) return $urandom_range(0, 127);
    top = (size + pad) / step;
    if (top > 127) top = 127;
    return $urandom_range(0, top);
  endfunction

  task automatic random_item();
    int eh, ew, pick;
    eh = sb.eff_height();
    ew = sb.eff_width();
    pick = $urandom_range(0, 99);
    if (pick < 45 && eh > 0 && ew > 0)
      push_query(near_pooled(int'(sb.cfg_regs[REG_STEP_ROWS]),
                             int'(sb.cfg_regs[REG_PAD_TOP_ROWS]), eh),
                 near_pooled(int'(sb.cfg_regs[REG_STEP_COLS]),
                             int'(sb.cfg_regs[REG_PAD_LEFT_COLS]), ew),
                 CH_W'($urandom));
    else if (pick < 85 && eh > 0 && ew > 0)
      push_load($urandom_range(0, eh - 1), $urandom_range(0, ew - 1), CH_W'($urandom),
                rand_sample());
    else if (pick < 93)
      push_load($urandom_range(0, 63), $urandom_range(0, 63), CH_W'($urandom), rand_sample());
    else
      push_query($urandom_range(0, 127), $urandom_range(0, 127), CH_W'($urandom));
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
      default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
    endcase
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_IMAGE_HEIGHT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    set_idling(0);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: a window of most negative samples, ties, and the top index.
    push_load(0, 0, 0, SAMPLE_MIN);
    push_load(0, 1, 0, SAMPLE_MIN);
    push_load(1, 0, 0, SAMPLE_MIN);
    push_load(1, 1, 0, SAMPLE_MIN);
    push_query(0, 0, 0);
    push_load(62, 62, 15, 16'sd7);
    push_load(62, 63, 15, 16'sd7);
    push_load(63, 62, 15, -16'sd1);
    push_load(63, 63, 15, 16'sd7);
    push_query(31, 31, 15);
    push_load(63, 63, 15, 16'sh7fff);
    push_query(31, 31, 15);
    push_query(32, 0, 0);
    push_query(127, 127, 15);

    // One-sample image; loads beyond it are dropped.
    apply_config(1, 1, 1, 1, 1, 1, 0, 0);
    push_load(0, 0, 9, rand_sample());
    push_load(0, 1, 9, rand_sample());
    push_load(1, 0, 9, rand_sample());
    push_query(0, 0, 9);
    push_query(1, 1, 9);

    // Large window and stride with the largest padding over a small image: one nearly full scan.
    apply_config(16, 16, 64, 64, 64, 64, 63, 63);
    push_query(0, 0, 7);
    push_query(1, 1, 7);
    push_query(2, 2, 7);
    push_query(1, 0, 7);

    // Empty image, empty window and zero stride together.
    apply_config(0, 0, 0, 0, 0, 0, 0, 0);
    push_load(0, 0, 2, rand_sample());
    push_query(0, 0, 2);
    push_query(127, 127, 2);

    // Oversized image saturates; the top padding keeps only its low six bits.
    apply_config(127, 100, 3, 3, 127, 127, 65, 0);
    push_query(0, 0, 15);
    push_query(1, 1, 15);
    push_query(0, 0, 0);

    // Zero-height window, then zero stride with padding.
    apply_config(8, 8, 0, 3, 1, 1, 0, 0);
    push_query(0, 0, 4);
    apply_config(6, 6, 3, 3, 0, 0, 1, 1);
    push_query(5, 9, 3);
    push_query(127, 0, 3);

    // Random phases over random geometries; one holds off the receiver for a while.
    for (int p = 0; p < 12; p++) begin
      apply_random_config();
      set_idling(p % 4);
      if (p == 4) hold_req = 1'b1;
      repeat (PHASE_PICKS) random_item();
    end

    await_results();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_maxima.size() == 0)
      $display("tb_max_pool_window_argmax_core OK");
    else
      $display("tb_max_pool_window_argmax_core NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
sv/mpwa_pkg.sv
sv/mpwa_ram.sv
sv/mpwa_ctrl.sv
sv/mpwa_dp.sv
sv/max_pool_window_argmax_core.sv
bench/tb_max_pool_window_argmax_core.sv
